// ===== rtl/bisp_pkg.sv =====
// Shared types, codes and helpers for the boot image section parser.
// No dependencies; used by every module of the block except bisp_fifo.
package bisp_pkg;

	localparam logic [31:0] VIRT_BASE = 32'h8000_0000;

	localparam int SIG_BYTES = 7;

	typedef enum logic [2:0] {
		EV_HEADER = 3'd0,
		EV_DATA   = 3'd1,
		EV_SECOK  = 3'd2,
		EV_CHKERR = 3'd3,
		EV_BADSIG = 3'd4,
		EV_END    = 3'd5,
		EV_IGNORE = 3'd6,
		EV_EMPTY  = 3'd7
	} event_t;

	typedef enum logic [7:0] {
		PH_SIG   = 8'b0000_0001,
		PH_SADDR = 8'b0000_0010,
		PH_SLEN  = 8'b0000_0100,
		PH_EADDR = 8'b0000_1000,
		PH_ELEN  = 8'b0001_0000,
		PH_ECHK  = 8'b0010_0000,
		PH_DATA  = 8'b0100_0000,
		PH_HOLD  = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		K_EVENT = 2'd0,
		K_LOAD  = 2'd1,
		K_DATA  = 2'd2
	} kind_t;

	typedef enum logic [7:0] {
		CFG_SDRAM_BASE = 8'd0,
		CFG_SIGNATURE  = 8'd1
	} cfg_reg_t;

	// front -> back command
	typedef struct packed {
		logic        start;
		kind_t       kind;
		event_t      ev;
		logic        last;
		logic [7:0]  data;
		logic [31:0] word;
		logic [31:0] img_start;
		logic [31:0] img_length;
	} cmd_t;

	// one result item
	typedef struct packed {
		event_t      ev;
		logic        wr_valid;
		logic [31:0] wr_addr;
		logic [7:0]  wr_byte;
		logic [15:0] sec_num;
		logic [31:0] img_start;
		logic [31:0] img_length;
	} res_t;

	function automatic logic [31:0] translate(input logic [31:0] a, input logic [31:0] base);
		translate = (a - VIRT_BASE) + base;
	endfunction

endpackage

// ===== rtl/bisp_fifo.sv =====
// Small register queue with full/empty flags, used between the parser stages.
// No package dependency.
module bisp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/bisp_front.sv =====
// Front end: signature check, header word assembly and section framing.
// Emits one cmd_t per accepted byte. Depends on bisp_pkg.
module bisp_front #(
	parameter int SIGNATURE_LENGTH = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         start_of_image,
	input  logic [7:0]                   data_byte,
	input  logic [31:0]                  sdram_base,
	input  logic [8*bisp_pkg::SIG_BYTES-1:0] signature_bytes,
	output bisp_pkg::cmd_t               cmd
);
	import bisp_pkg::*;

	phase_t      ph_q, ph_e, ph_d;
	logic [2:0]  bc_q, bc_e, bc_d;
	logic [31:0] wa_q, wa_d, word_new;
	logic [31:0] saddr_q, saddr_d;
	logic [31:0] slen_q, slen_d;
	logic [31:0] secaddr_q, secaddr_d;
	logic [31:0] seclen_q, seclen_d;
	logic [31:0] chk_q, chk_d;
	logic [31:0] rem_q, rem_d;
	logic [63:0] sig_ext;
	logic [7:0]  exp_byte;

	assign sig_ext  = {{(64 - 8*SIG_BYTES){1'b0}}, signature_bytes};
	assign exp_byte = sig_ext[bc_e*8 +: 8];

	always_comb begin
		ph_e      = start_of_image ? PH_SIG : ph_q;
		bc_e      = start_of_image ? 3'd0 : bc_q;
		ph_d      = ph_e;
		bc_d      = bc_e;
		wa_d      = wa_q;
		saddr_d   = saddr_q;
		slen_d    = slen_q;
		secaddr_d = secaddr_q;
		seclen_d  = seclen_q;
		chk_d     = chk_q;
		rem_d     = rem_q;
		word_new  = wa_q;
		word_new[bc_e[1:0]*8 +: 8] = data_byte;

		cmd            = '0;
		cmd.start      = start_of_image;
		cmd.kind       = K_EVENT;
		cmd.ev         = EV_IGNORE;
		cmd.data       = data_byte;

		unique case (ph_e)
			PH_SIG: begin
				if (!start_of_image && bc_e == 3'd0) begin
					cmd.ev = EV_IGNORE;
				end else if (data_byte != exp_byte) begin
					cmd.ev = EV_BADSIG;
					ph_d   = PH_HOLD;
				end else begin
					cmd.ev = EV_HEADER;
					if (bc_e == 3'(SIGNATURE_LENGTH - 1)) begin
						bc_d = 3'd0;
						ph_d = PH_SADDR;
					end else begin
						bc_d = bc_e + 3'd1;
					end
				end
			end
			PH_SADDR, PH_SLEN, PH_EADDR, PH_ELEN, PH_ECHK: begin
				cmd.ev = EV_HEADER;
				if (bc_e[1:0] == 2'd3) begin
					bc_d = 3'd0;
					unique case (ph_e)
						PH_SADDR: begin
							saddr_d = translate(word_new, sdram_base);
							ph_d    = PH_SLEN;
						end
						PH_SLEN: begin
							slen_d = word_new;
							ph_d   = PH_EADDR;
						end
						PH_EADDR: begin
							secaddr_d = word_new;
							ph_d      = PH_ELEN;
						end
						PH_ELEN: begin
							seclen_d = word_new;
							ph_d     = PH_ECHK;
						end
						default: begin
							chk_d = word_new;
							if (secaddr_q == '0) begin
								cmd.ev         = EV_END;
								cmd.img_start  = saddr_q;
								cmd.img_length = slen_q;
								ph_d           = PH_HOLD;
							end else if (seclen_q == '0) begin
								if (word_new == '0) begin
									cmd.ev = EV_EMPTY;
									ph_d   = PH_EADDR;
								end else begin
									cmd.ev = EV_CHKERR;
									ph_d   = PH_HOLD;
								end
							end else begin
								cmd.kind = K_LOAD;
								cmd.word = translate(secaddr_q, sdram_base);
								rem_d    = seclen_q;
								ph_d     = PH_DATA;
							end
						end
					endcase
				end else begin
					bc_d = bc_e + 3'd1;
					wa_d = word_new;
				end
			end
			PH_DATA: begin
				cmd.kind = K_DATA;
				cmd.ev   = EV_DATA;
				cmd.word = chk_q;
				cmd.last = (rem_q == 32'd1);
				rem_d    = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					bc_d = 3'd0;
					ph_d = PH_EADDR;
				end
			end
			default: begin
				cmd.ev = EV_IGNORE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_SIG;
			bc_q <= 3'd0;
		end else if (accept) begin
			ph_q <= ph_d;
			bc_q <= bc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wa_q      <= wa_d;
			saddr_q   <= saddr_d;
			slen_q    <= slen_d;
			secaddr_q <= secaddr_d;
			seclen_q  <= seclen_d;
			chk_q     <= chk_d;
			rem_q     <= rem_d;
		end
	end

endmodule

// ===== rtl/bisp_back.sv =====
// Back end: section data writes, running checksum and section count.
// Turns each cmd_t into one res_t. Depends on bisp_pkg.
module bisp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  bisp_pkg::cmd_t cmd,
	output bisp_pkg::res_t res
);
	import bisp_pkg::*;

	logic        hold_q, hold_e, hold_d;
	logic [15:0] cnt_q, cnt_e, cnt_d;
	logic [31:0] ptr_q, ptr_d;
	logic [31:0] sum_q, sum_d, sum_new;

	assign sum_new = sum_q + {24'd0, cmd.data};

	always_comb begin
		hold_e = cmd.start ? 1'b0 : hold_q;
		cnt_e  = cmd.start ? 16'd0 : cnt_q;
		hold_d = hold_e;
		cnt_d  = cnt_e;
		ptr_d  = ptr_q;
		sum_d  = sum_q;

		res         = '0;
		res.ev      = EV_IGNORE;
		res.sec_num = cnt_e;

		if (!hold_e) begin
			unique case (cmd.kind)
				K_DATA: begin
					res.wr_valid = 1'b1;
					res.wr_addr  = ptr_q;
					res.wr_byte  = cmd.data;
					res.ev       = EV_DATA;
					ptr_d        = ptr_q + 32'd1;
					sum_d        = sum_new;
					if (cmd.last) begin
						if (sum_new == cmd.word) begin
							res.ev = EV_SECOK;
							cnt_d  = cnt_e + 16'd1;
						end else begin
							res.ev = EV_CHKERR;
							hold_d = 1'b1;
						end
					end
				end
				K_LOAD: begin
					res.ev = cmd.ev;
					ptr_d  = cmd.word;
					sum_d  = '0;
				end
				default: begin
					res.ev         = cmd.ev;
					res.img_start  = cmd.img_start;
					res.img_length = cmd.img_length;
					if (cmd.ev == EV_EMPTY) begin
						cnt_d = cnt_e + 16'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			cnt_q  <= 16'd0;
		end else if (step) begin
			hold_q <= hold_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ptr_q <= ptr_d;
			sum_q <= sum_d;
		end
	end

endmodule

// ===== rtl/boot_image_section_parser.sv =====
// Top level of the boot image section parser: config registers, front end,
// command queue, back end and result queue. Depends on bisp_pkg and all bisp_* modules.
//
// Takes one image byte per clock (unless the command queue is full) and gives one
// result per byte in the same order. The front end advances the signature/header
// parse state for each byte as it is accepted, so bytes can be pushed back to back; a
// byte's result is visible after the command queue and then the result queue, and each
// side can stall on its own. A start_of_image byte restarts parsing wherever
// it arrives. Configuration writes are taken at any time (cfg_ready is always
// high) but must only be issued while no result is pending.
module boot_image_section_parser #(
	parameter int SIGNATURE_LENGTH = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        start_of_image,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_res,
	output logic        write_valid,
	output logic [31:0] write_address,
	output logic [7:0]  write_byte,
	output logic [15:0] section_number,
	output logic [31:0] image_start,
	output logic [31:0] image_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import bisp_pkg::*;

	logic [31:0]            base_q;
	logic [8*SIG_BYTES-1:0] sig_q;
	logic                   accept;
	cmd_t                   cmd_in, cmd_out;
	logic                   cmd_full, cmd_empty;
	logic                   step;
	res_t                   res_in, res_out;
	logic                   res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			sig_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SDRAM_BASE: base_q <= cfg_data[31:0];
				CFG_SIGNATURE:  sig_q  <= cfg_data[8*SIG_BYTES-1:0];
				default: ;
			endcase
		end
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	bisp_front #(
		.SIGNATURE_LENGTH(SIGNATURE_LENGTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.start_of_image (start_of_image),
		.data_byte      (data_byte),
		.sdram_base     (base_q),
		.signature_bytes(sig_q),
		.cmd            (cmd_in)
	);

	bisp_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(cmd_in),
		.rd_en  (step),
		.rd_data(cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	assign step = !cmd_empty && !res_full;

	bisp_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.cmd   (cmd_out),
		.res   (res_in)
	);

	bisp_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (step),
		.wr_data(res_in),
		.rd_en  (pop),
		.rd_data(res_out),
		.full   (res_full),
		.empty  (empty)
	);

	assign event_res      = res_out.ev;
	assign write_valid    = res_out.wr_valid;
	assign write_address  = res_out.wr_addr;
	assign write_byte     = res_out.wr_byte;
	assign section_number = res_out.sec_num;
	assign image_start    = res_out.img_start;
	assign image_length   = res_out.img_length;

endmodule

// ===== dv/boot_image_section_checker.sv =====
// Checker for the boot image section parser: tracks input, result and config transfers,
// predicts each result from its own parse state and compares field by field.
// Depends on bisp_pkg.
module boot_image_section_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        start_of_image,
	input  logic [7:0]  data_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  event_res,
	input  logic        write_valid,
	input  logic [31:0] write_address,
	input  logic [7:0]  write_byte,
	input  logic [15:0] section_number,
	input  logic [31:0] image_start,
	input  logic [31:0] image_length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import bisp_pkg::*;

	logic [31:0] base_reg;
	logic [55:0] sig_reg;

	phase_t      ph;
	logic [2:0]  bcnt;
	logic [31:0] wacc;
	logic [31:0] img_addr;
	logic [31:0] img_len;
	logic [31:0] sec_addr;
	logic [31:0] sec_len;
	logic [31:0] sec_chk;
	logic [31:0] wptr;
	logic [31:0] done_cnt;
	logic [31:0] sum;
	logic [15:0] sec_cnt;

	res_t parser_events_q[$];

	function automatic logic [31:0] to_phys(input logic [31:0] a);
		return a - VIRT_BASE + base_reg;
	endfunction

	function automatic void clear_parse();
		ph = PH_SIG;
		bcnt = '0;
		wacc = '0;
		img_addr = '0;
		img_len = '0;
		sec_addr = '0;
		sec_len = '0;
		sec_chk = '0;
		wptr = '0;
		done_cnt = '0;
		sum = '0;
		sec_cnt = '0;
	endfunction

	function automatic res_t parse_image_byte(input logic sob, input logic [7:0] b);
		res_t r;
		r = '0;
		r.ev = EV_IGNORE;
		if (sob)
			clear_parse();
		r.sec_num = sec_cnt;
		unique case (ph)
			PH_SIG: begin
				if (sob || bcnt != 0) begin
					if (b != sig_reg[8*bcnt +: 8]) begin
						r.ev = EV_BADSIG;
						ph = PH_HOLD;
					end else begin
						r.ev = EV_HEADER;
						bcnt = bcnt + 3'd1;
						if (bcnt >= SIG_BYTES) begin
							bcnt = '0;
							wacc = '0;
							ph = PH_SADDR;
						end
					end
				end
			end
			PH_SADDR, PH_SLEN, PH_EADDR, PH_ELEN, PH_ECHK: begin
				r.ev = EV_HEADER;
				wacc[8*bcnt[1:0] +: 8] = b;
				bcnt = bcnt + 3'd1;
				if (bcnt >= 3'd4) begin
					bcnt = '0;
					unique case (ph)
						PH_SADDR: begin
							img_addr = to_phys(wacc);
							ph = PH_SLEN;
						end
						PH_SLEN: begin
							img_len = wacc;
							ph = PH_EADDR;
						end
						PH_EADDR: begin
							sec_addr = wacc;
							ph = PH_ELEN;
						end
						PH_ELEN: begin
							sec_len = wacc;
							ph = PH_ECHK;
						end
						default: begin
							sec_chk = wacc;
							if (sec_addr == 0) begin
								r.ev = EV_END;
								r.img_start = img_addr;
								r.img_length = img_len;
								ph = PH_HOLD;
							end else begin
								wptr = to_phys(sec_addr);
								sum = '0;
								done_cnt = '0;
								if (sec_len == 0) begin
									if (sec_chk == 0) begin
										r.ev = EV_EMPTY;
										sec_cnt = sec_cnt + 16'd1;
										ph = PH_EADDR;
									end else begin
										r.ev = EV_CHKERR;
										ph = PH_HOLD;
									end
								end else begin
									ph = PH_DATA;
								end
							end
						end
					endcase
					wacc = '0;
				end
			end
			PH_DATA: begin
				r.ev = EV_DATA;
				r.wr_valid = 1'b1;
				r.wr_addr = wptr;
				r.wr_byte = b;
				sum = sum + 32'(b);
				wptr = wptr + 32'd1;
				done_cnt = done_cnt + 32'd1;
				if (done_cnt == sec_len) begin
					if (sum == sec_chk) begin
						r.ev = EV_SECOK;
						sec_cnt = sec_cnt + 16'd1;
						bcnt = '0;
						wacc = '0;
						ph = PH_EADDR;
					end else begin
						r.ev = EV_CHKERR;
						ph = PH_HOLD;
					end
				end
			end
			default: r.ev = EV_IGNORE;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			base_reg = '0;
			sig_reg = '0;
			clear_parse();
			parser_events_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SDRAM_BASE: base_reg = cfg_data[31:0];
					CFG_SIGNATURE: sig_reg = cfg_data[55:0];
					default: ;
				endcase
			end
			if (push && !full)
				parser_events_q.push_back(parse_image_byte(start_of_image, data_byte));
			if (pop && !empty) begin
				if (parser_events_q.size() == 0) begin
					errors++;
					$display("%0t: result mismatch: expected none, actual event %0d",
						$time, event_res);
				end else begin
					want = parser_events_q.pop_front();
					check_field("event_res", want.ev, event_res);
					check_field("write_valid", want.wr_valid, write_valid);
					check_field("write_address", want.wr_addr, write_address);
					check_field("write_byte", want.wr_byte, write_byte);
					check_field("section_number", want.sec_num, section_number);
					check_field("image_start", want.img_start, image_start);
					check_field("image_length", want.img_length, image_length);
				end
			end
			pending = parser_events_q.size();
		end
	end

endmodule

// ===== dv/boot_image_section_parser_tb.sv =====
// Top of the boot image section parser testbench: clock, reset, image stream stimulus,
// result-side stalls and the verdict. Depends on bisp_pkg, the parser RTL and
// boot_image_section_checker.
module boot_image_section_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bisp_pkg::*;

	typedef struct packed {
		logic       sob;
		logic [7:0] b;
	} stream_byte_t;

	typedef enum int {
		IMG_GOOD,
		IMG_CHKERR,
		IMG_EMPTY_OK,
		IMG_EMPTY_BAD,
		IMG_CUT,
		IMG_BADSIG,
		IMG_WRAP,
		IMG_ZERO_PHYS,
		IMG_NOISE
	} image_kind_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        start_of_image;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  event_res;
	logic        write_valid;
	logic [31:0] write_address;
	logic [7:0]  write_byte;
	logic [15:0] section_number;
	logic [31:0] image_start;
	logic [31:0] image_length;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;

	int fail_count;
	int in_flight;

	logic [31:0]  base_val;
	logic [55:0]  sig_val;
	stream_byte_t image_bytes[$];
	int           burst_left;
	int           bytes_sent;
	int           hold_asks;
	int           holds_done;

	boot_image_section_parser dut (.*);

	boot_image_section_checker u_checker (
		.*,
		.errors (fail_count),
		.pending(in_flight)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1ms;
		$display("DONE: errors detected");
		$finish;
	end

	// result side: stall pattern drawn at random from four modes; long hold on request
	initial begin
		int cyc;
		int rx_mode;
		cyc = 0;
		rx_mode = 0;
		holds_done = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 50 == 0)
				rx_mode = $urandom_range(0, 3);
			if (holds_done != hold_asks) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				holds_done++;
			end else begin
				unique case (rx_mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ((cyc % 8) >= 5);
				endcase
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] base, input logic [55:0] sig);
		write_reg(CFG_SDRAM_BASE, {32'h0, base});
		write_reg(CFG_SIGNATURE, {8'h0, sig});
		base_val = base;
		sig_val = sig;
	endtask

	task automatic send_byte(input logic sob, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		push <= 1'b1;
		start_of_image <= sob;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_queued();
		stream_byte_t it;
		while (image_bytes.size() != 0) begin
			it = image_bytes.pop_front();
			send_byte(it.sob, it.b);
		end
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	function automatic void add_byte(input logic sob, input logic [7:0] b);
		image_bytes.push_back('{sob: sob, b: b});
	endfunction

	function automatic void put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			add_byte(1'b0, w[8*i +: 8]);
	endfunction

	task automatic build_image(input image_kind_t kind);
		int          first;
		int          nsec;
		int          bad_sec;
		int          bad_pos;
		int          cut;
		logic [31:0] raw;
		logic [31:0] len;
		logic [31:0] chk;
		logic [7:0]  b;
		logic [7:0]  dat[$];
		first = image_bytes.size();
		if (kind == IMG_NOISE) begin
			repeat ($urandom_range(5, 20))
				add_byte($urandom_range(0, 7) == 0, 8'($urandom));
			return;
		end
		nsec = $urandom_range(1, 4);
		bad_sec = $urandom_range(0, nsec - 1);
		bad_pos = $urandom_range(0, SIG_BYTES - 1);
		for (int i = 0; i < SIG_BYTES; i++) begin
			b = sig_val[8*i +: 8];
			if (kind == IMG_BADSIG && i == bad_pos)
				b ^= 8'(1 << $urandom_range(0, 7));
			add_byte(i == 0, b);
		end
		put_word(($urandom_range(0, 3) == 0) ? VIRT_BASE : 32'($urandom));
		put_word($urandom);
		for (int s = 0; s < nsec; s++) begin
			unique case (kind)
				IMG_WRAP: raw = (32'hFFFF_FFFF - $urandom_range(0, 3)) - base_val + VIRT_BASE;
				IMG_ZERO_PHYS: raw = VIRT_BASE - base_val;
				default: raw = $urandom;
			endcase
			if (raw == 0)
				raw = 32'h1;
			if ((kind == IMG_EMPTY_OK && s % 2 == 0) || (kind == IMG_EMPTY_BAD && s == bad_sec))
				len = 0;
			else if ($urandom_range(0, 9) == 0)
				len = 0;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(7, 40);
			else
				len = $urandom_range(1, 6);
			put_word(raw);
			put_word(len);
			chk = 0;
			dat.delete();
			for (int k = 0; k < len; k++) begin
				b = 8'($urandom);
				dat.push_back(b);
				chk += 32'(b);
			end
			if (kind == IMG_CHKERR && s == bad_sec)
				chk ^= 32'(1) << $urandom_range(0, 31);
			if (kind == IMG_EMPTY_BAD && s == bad_sec)
				chk = 32'($urandom) | 32'h1;
			put_word(chk);
			foreach (dat[k])
				add_byte(1'b0, dat[k]);
		end
		put_word(32'h0);
		put_word($urandom);
		put_word($urandom);
		repeat ($urandom_range(0, 3))
			add_byte(1'b0, 8'($urandom));
		if (kind == IMG_CUT) begin
			cut = $urandom_range(1, image_bytes.size() - first - 1);
			while (image_bytes.size() > first + cut)
				void'(image_bytes.pop_back());
		end
	endtask

	task automatic run_images(input int target);
		int          stop_at;
		int          r;
		image_kind_t kind;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 17);
			kind = (r < 10) ? IMG_GOOD : image_kind_t'(r - 9);
			build_image(kind);
			send_queued();
		end
	endtask

	initial begin
		logic [7:0] s[SIG_BYTES];
		arst_n <= 1'b0;
		push <= 1'b0;
		start_of_image <= 1'b0;
		data_byte <= 8'h0;
		cfg_valid <= 1'b0;
		cfg_index <= 8'h0;
		cfg_data <= 64'h0;
		burst_left = 0;
		bytes_sent = 0;
		hold_asks = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(32'h0, 56'({$urandom, $urandom}));
		for (int i = 0; i < SIG_BYTES; i++)
			s[i] = sig_val[8*i +: 8];
		// bytes before any start marker
		add_byte(1'b0, 8'h00);
		add_byte(1'b0, 8'hFF);
		add_byte(1'b0, 8'h5A);
		// bad first signature byte, then held bytes
		add_byte(1'b1, s[0] ^ 8'hFF);
		add_byte(1'b0, s[1]);
		add_byte(1'b0, 8'hFF);
		// mismatch on a later signature byte
		add_byte(1'b1, s[0]);
		add_byte(1'b0, s[1]);
		add_byte(1'b0, s[2] ^ 8'h80);
		// restart in the middle of the signature, then in the header
		add_byte(1'b1, s[0]);
		add_byte(1'b0, s[1]);
		add_byte(1'b1, s[0]);
		for (int i = 1; i < SIG_BYTES; i++)
			add_byte(1'b0, s[i]);
		add_byte(1'b0, 8'hFF);
		add_byte(1'b0, 8'h00);
		add_byte(1'b0, 8'hFF);
		add_byte(1'b0, 8'h7F);
		add_byte(1'b1, s[0]);
		send_queued();
		for (int k = 0; k <= IMG_NOISE; k++) begin
			build_image(image_kind_t'(k));
			send_queued();
		end
		run_images(30);
		wait_idle();

		set_config(32'hFFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF);
		run_images(25);
		wait_idle();

		set_config(VIRT_BASE, 56'h0);
		hold_asks++;
		run_images(25);
		wait_idle();

		set_config($urandom, 56'({$urandom, $urandom}));
		hold_asks++;
		run_images(25);
		wait_idle();

		set_config($urandom, 56'({$urandom, $urandom}));
		run_images(25);
		wait_idle();

		set_config(32'h0, 56'({$urandom, $urandom}));
		run_images(25);
		wait_idle();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bisp_pkg.sv
rtl/bisp_fifo.sv
rtl/bisp_front.sv
rtl/bisp_back.sv
rtl/boot_image_section_parser.sv
dv/boot_image_section_checker.sv
dv/boot_image_section_parser_tb.sv
